[rtl/core/bpfa_pkg.sv]
// Shared widths, codes and controller/datapath handshake types for the page allocator.
package bpfa_pkg;

   // field widths of the request, result and register
   localparam int CMD_W      = 1;
   localparam int START_W    = 12;
   localparam int COUNT_W    = 13;
   localparam int INDEX_W    = 12;
   localparam int MANAGED_W  = 13;

   // default bitmap size and register reset
   localparam int          MAX_PAGES_DEF = 4096;
   localparam int unsigned MANAGED_RESET = 4096;

   // bitmap storage word: pages held in one RAM entry
   localparam int WORD_BITS  = 8;
   localparam int WORD_SEL_W = $clog2(WORD_BITS);

   // command codes
   localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load;        // latch an accepted request
      logic init_step;   // write one all-used word of the clearing pass
      logic scan_prime;  // read the first word of the search
      logic scan_step;   // evaluate one word, fetch the next
      logic mark_rd;     // fetch a word of the run being marked
      logic mark_wr;     // write that word back with the run bits changed
      logic load_rsp;    // move the result into the output register
   } bpfa_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic init_last;   // clearing pass is at its final word
      logic skip;        // request needs no bitmap access
      logic is_free;     // latched request frees a run
      logic hit;         // the word under evaluation completes a run
      logic scan_last;   // the word under evaluation is the last one searched
      logic mark_last;   // the word being marked is the last of the run
   } bpfa_sts_type;

endpackage

[rtl/core/bpfa_if.sv]
// Request and result channel interfaces of the page allocator.
interface bpfa_req_if import bpfa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [START_W-1:0] start_page;
   logic [COUNT_W-1:0] page_count;

   modport source (output valid, command, start_page, page_count, input ready);
   modport sink   (input valid, command, start_page, page_count, output ready);
endinterface

interface bpfa_rsp_if import bpfa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               found;
   logic [INDEX_W-1:0] page_index;

   modport source (output valid, found, page_index, input ready);
   modport sink   (input valid, found, page_index, output ready);
endinterface

[rtl/core/bpfa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bpfa_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 512,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/bpfa_datapath.sv]
// Bitmap storage, search evaluation, run marking and result registers.
module bpfa_datapath import bpfa_pkg::*; #(
   parameter int MAX_PAGES = MAX_PAGES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bpfa_cmd_type         cmd,
   output bpfa_sts_type         sts,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [START_W-1:0]   req_start_page,
   input  logic [COUNT_W-1:0]   req_page_count,
   input  logic                 csr_wr_en,
   input  logic [MANAGED_W-1:0] csr_wr_data,
   output logic                 rsp_found,
   output logic [INDEX_W-1:0]   rsp_page_index
);

   localparam int DEPTH = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PGW   = AW + WORD_SEL_W;
   localparam int CW    = (PGW + 1 > 14) ? PGW + 1 : 14;
   localparam logic [CW-1:0] MAX_W = CW'(MAX_PAGES);

   logic [MANAGED_W-1:0] managed_ff;
   logic                 free_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [CW-1:0]        lim_ff;
   logic                 skip_ff;
   logic [PGW-1:0]       lo_ff, lo_in;
   logic [PGW-1:0]       hi_ff, hi_in;
   logic [AW-1:0]        word_ff;
   logic [COUNT_W-1:0]   run_ff;
   logic                 found_ff;
   logic                 rsp_found_ff;
   logic [INDEX_W-1:0]   rsp_index_ff;

   logic [CW-1:0]        start_w, end_w, end_cap, managed_w, lim_in;
   logic                 req_free, skip_in;

   logic [WORD_BITS-1:0] rd_data, wr_data, in_range, in_run;
   logic                 ram_rd_en, ram_wr_en;
   logic [AW-1:0]        ram_rd_addr;

   logic                 hit;
   logic [PGW-1:0]       hit_pg, first_pg;
   logic [COUNT_W-1:0]   run_out;
   logic                 scan_last;
   logic [CW-1:0]        last_pg;

   // request decode at acceptance
   always_comb begin
      req_free  = (req_command == CMD_FREE);
      start_w   = CW'(req_start_page);
      end_w     = start_w + CW'(req_page_count);
      end_cap   = (end_w > MAX_W) ? MAX_W : end_w;
      managed_w = CW'(managed_ff);
      lim_in    = (managed_w > MAX_W) ? MAX_W : managed_w;
      lo_in     = PGW'(start_w);
      hi_in     = PGW'(end_cap - CW'(1));
      if (req_free) begin
         skip_in = (req_page_count == '0) || (start_w >= MAX_W);
      end else begin
         skip_in = (req_page_count == '0) || (lim_in == '0);
      end
   end

   // per-page flags of the current word: inside the search, inside the run
   always_comb begin
      logic [PGW-1:0] pg;
      for (int j = 0; j < WORD_BITS; j++) begin
         pg          = {word_ff, WORD_SEL_W'(j)};
         in_range[j] = (CW'(pg) < lim_ff);
         in_run[j]   = (pg >= lo_ff) && (pg <= hi_ff);
      end
   end

   // first-fit evaluation of one word, run length carried from the last
   always_comb begin
      logic [COUNT_W-1:0] run;
      logic               got;
      logic [PGW-1:0]     got_pg;
      run    = run_ff;
      got    = 1'b0;
      got_pg = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         if (!got && in_range[j]) begin
            if (rd_data[j]) begin
               run = '0;
            end else begin
               run = run + COUNT_W'(1);
               if (run == count_ff) begin
                  got    = 1'b1;
                  got_pg = {word_ff, WORD_SEL_W'(j)};
               end
            end
         end
      end
      run_out  = run;
      hit      = got & cmd.scan_step;
      hit_pg   = got_pg;
      first_pg = PGW'(CW'(got_pg) + CW'(1) - CW'(count_ff));
   end

   assign last_pg   = CW'({word_ff, {WORD_SEL_W{1'b1}}});
   assign scan_last = (last_pg + CW'(1)) >= lim_ff;

   // bitmap RAM access
   always_comb begin
      ram_rd_en   = cmd.scan_prime | cmd.mark_rd | (cmd.scan_step & ~hit & ~scan_last);
      ram_rd_addr = cmd.scan_step ? word_ff + AW'(1) : word_ff;
      ram_wr_en   = cmd.init_step | cmd.mark_wr;
      if (cmd.init_step) begin
         wr_data = '1;
      end else if (free_ff) begin
         wr_data = rd_data & ~in_run;
      end else begin
         wr_data = rd_data | in_run;
      end
   end

   bpfa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH),
      .ADDR_W(AW)
   ) u_map (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(word_ff),
      .wr_data(wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(rd_data)
   );

   // control counters and register
   always_ff @(posedge clock) begin
      if (reset) begin
         managed_ff <= MANAGED_W'(MANAGED_RESET);
         word_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            managed_ff <= csr_wr_data;
         end
         if (cmd.load) begin
            word_ff <= req_free ? lo_in[PGW-1:WORD_SEL_W] : '0;
         end else if (cmd.scan_step && hit) begin
            word_ff <= first_pg[PGW-1:WORD_SEL_W];
         end else if (cmd.init_step || cmd.mark_wr || cmd.scan_step) begin
            word_ff <= word_ff + AW'(1);
         end
      end
   end

   // request, run and result payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         free_ff  <= req_free;
         count_ff <= req_page_count;
         lim_ff   <= lim_in;
         skip_ff  <= skip_in;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         run_ff   <= '0;
         found_ff <= req_free;
      end
      if (cmd.scan_step) begin
         run_ff <= run_out;
         if (hit) begin
            lo_ff    <= first_pg;
            hi_ff    <= hit_pg;
            found_ff <= 1'b1;
         end
      end
      if (cmd.load_rsp) begin
         rsp_found_ff <= found_ff;
         rsp_index_ff <= (free_ff || !found_ff) ? '0 : INDEX_W'(CW'(lo_ff));
      end
   end

   always_comb begin
      sts.init_last = (word_ff == AW'(DEPTH - 1));
      sts.skip      = skip_ff;
      sts.is_free   = free_ff;
      sts.hit       = hit;
      sts.scan_last = scan_last;
      sts.mark_last = (word_ff == hi_ff[PGW-1:WORD_SEL_W]);
   end

   assign rsp_found      = rsp_found_ff;
   assign rsp_page_index = rsp_index_ff;

endmodule

[rtl/core/bpfa_ctrl.sv]
// Sequencer for the clearing pass, first-fit search and run marking.
module bpfa_ctrl import bpfa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output bpfa_cmd_type cmd,
   input  bpfa_sts_type sts
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.init_step = 1'b1;
            if (sts.init_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (sts.skip) begin
               state_in = ST_DONE;
            end else if (sts.is_free) begin
               state_in = ST_MARK_RD;
            end else begin
               cmd.scan_prime = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.hit) begin
               state_in = ST_MARK_RD;
            end else if (sts.scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_MARK_RD: begin
            cmd.mark_rd = 1'b1;
            state_in    = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            cmd.mark_wr = 1'b1;
            state_in    = sts.mark_last ? ST_DONE : ST_MARK_RD;
         end
         ST_DONE: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result beat valid: set on load, cleared when taken
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   // a run is only found while searching
   assert property (@(posedge clock) disable iff (reset)
      sts.hit |-> (state_ff == ST_SCAN))
      else $error("run found outside the search");

   // a result beat only appears from the finishing state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result beat raised outside the finishing state");

   // every bitmap write-back follows the read of that word
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK_WR) |-> ($past(state_ff) == ST_MARK_RD))
      else $error("bitmap write-back without a preceding read");

   // the output register is never overwritten while a beat waits
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before it was taken");
`endif

endmodule

[rtl/core/bitmap_page_frame_allocator_unit.sv]
// Top level of the bitmap first-fit page frame allocator.
// One bit per page frame is held in a RAM of 8-page words, and every page reads as used after
// reset: a clearing pass writes the whole bitmap, one word a cycle, before the first request
// beat is taken; register writes are taken throughout. Requests are worked one at a time. An
// allocate passes a start state, then searches word by word from page 0 up to the end of the
// first fitting run (or to the managed limit on a miss), then reads and writes back each word
// the run touches, and then loads the result. A free passes the start state, then reads and
// writes back each word it touches and loads the result; an empty or out-of-range free
// finishes without touching the bitmap. The bitmap RAM has a single read and write port. The
// next request is taken while a result beat still waits in the output register.
module bitmap_page_frame_allocator_unit import bpfa_pkg::*; #(
   parameter int MAX_PAGES = MAX_PAGES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   bpfa_req_if.sink             req_bus,
   bpfa_rsp_if.source           rsp_bus,
   input  logic                 csr_wr_en,
   input  logic [MANAGED_W-1:0] csr_wr_data
);

   bpfa_cmd_type cmd;
   bpfa_sts_type sts;

   // sequencer
   bpfa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_bus.valid),
      .req_ready(req_bus.ready),
      .rsp_valid(rsp_bus.valid),
      .rsp_ready(rsp_bus.ready),
      .cmd      (cmd),
      .sts      (sts)
   );

   // bitmap and arithmetic
   bpfa_datapath #(
      .MAX_PAGES(MAX_PAGES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_command   (req_bus.command),
      .req_start_page(req_bus.start_page),
      .req_page_count(req_bus.page_count),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_found     (rsp_bus.found),
      .rsp_page_index(rsp_bus.page_index)
   );

endmodule

[tb/sv/bitmap_page_frame_allocator_unit_tb.sv]
// Self-checking testbench for the bitmap first-fit page frame allocator.
`timescale 1ns / 100ps

module bitmap_page_frame_allocator_unit_tb import bpfa_pkg::*; ();

   localparam int PAGES       = MAX_PAGES_DEF;
   localparam int STALL_LIMIT = 12000;   // cycles with no beat on either channel
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] page_index;
   } page_grant_type;

   typedef struct {
      logic [START_W-1:0] first;
      logic [COUNT_W-1:0] count;
   } page_run_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [MANAGED_W-1:0] csr_wr_data;

   bpfa_req_if req_bus ();
   bpfa_rsp_if rsp_bus ();

   bitmap_page_frame_allocator_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // shadow of the allocator: bitmap, managed page count, pending grants
   logic [PAGES-1:0]     page_used;
   logic [MANAGED_W-1:0] managed_model;
   page_grant_type       pending_grants[$];
   page_run_type         held_runs[$];

   // knobs shared by the tests and the result sink
   bit send_gaps_on;
   bit rsp_stalls_on;
   int rsp_hold_left;
   int rsp_stall_left;

   // run statistics
   int n_alloc, n_granted, n_free, n_settings, n_checked, n_mismatch;
   int idle_cycles;

   // clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // gap length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      else if (r < 92) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   // run length: mostly small, rarely beyond the bitmap
   function automatic logic [COUNT_W-1:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return COUNT_W'($urandom_range(1, 8));
      else if (r < 90) return COUNT_W'($urandom_range(9, 64));
      else if (r < 98) return COUNT_W'($urandom_range(65, 512));
      else return COUNT_W'($urandom_range(513, 8191));
   endfunction

   // predicted grant for one accepted beat; updates the shadow bitmap
   function automatic page_grant_type model_request(input logic [CMD_W-1:0] cmd,
                                                    input logic [START_W-1:0] start,
                                                    input logic [COUNT_W-1:0] count);
      page_grant_type g;
      int lim;
      int run;
      int p;
      int k;
      int first;
      g = '0;
      if (cmd == CMD_FREE) begin
         // clear the run, pages past the bitmap are dropped
         for (k = 0; k < int'(count); k++) begin
            p = int'(start) + k;
            if (p >= PAGES) break;
            page_used[p] = 1'b0;
         end
         g.found = 1'b1;
      end else if (count != 0) begin
         // first fit from page 0 inside the managed range
         lim = (int'(managed_model) > PAGES) ? PAGES : int'(managed_model);
         run = 0;
         for (p = 0; p < lim; p++) begin
            if (page_used[p]) begin
               run = 0;
            end else begin
               run++;
               if (run == int'(count)) begin
                  first = p + 1 - int'(count);
                  for (k = first; k <= p; k++) page_used[k] = 1'b1;
                  g.found      = 1'b1;
                  g.page_index = first[INDEX_W-1:0];
                  break;
               end
            end
         end
      end
      return g;
   endfunction

   // one request beat; called and returns at a falling edge
   task automatic send_request(input logic [CMD_W-1:0] cmd,
                               input logic [START_W-1:0] start,
                               input logic [COUNT_W-1:0] count,
                               output page_grant_type grant);
      int gap;
      gap = send_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.command    = cmd;
      req_bus.start_page = start;
      req_bus.page_count = count;
      req_bus.valid      = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      grant = model_request(cmd, start, count);
      pending_grants.push_back(grant);
      if (cmd == CMD_FREE) begin
         n_free++;
      end else begin
         n_alloc++;
         if (grant.found) n_granted++;
      end
      @(negedge clock);
   endtask

   // stop offering and wait until every grant has come back
   task automatic wait_drained();
      req_bus.valid = 1'b0;
      while (pending_grants.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // register write while the block is idle
   task automatic write_managed_pages(input logic [MANAGED_W-1:0] pages);
      wait_drained();
      csr_wr_en   = 1'b1;
      csr_wr_data = pages;
      @(negedge clock);
      csr_wr_en     = 1'b0;
      managed_model = pages;
      n_settings++;
   endtask

   // everything reads as used straight after reset
   task automatic test_after_reset();
      page_grant_type g;
      send_request(CMD_ALLOC, 12'd0, 13'd1, g);
      send_request(CMD_ALLOC, 12'hFFF, 13'd0, g);
      send_request(CMD_FREE, 12'd0, 13'd0, g);
      send_request(CMD_ALLOC, 12'd0, 13'd4096, g);
   endtask

   // boundaries of the fields and of the managed range
   task automatic test_edge_cases();
      page_grant_type g;
      write_managed_pages(13'd4096);
      send_request(CMD_FREE, 12'd0, 13'd4096, g);      // whole bitmap free
      send_request(CMD_FREE, 12'd100, 13'd50, g);      // already free
      send_request(CMD_ALLOC, 12'd0, 13'd4096, g);     // exact fit of everything
      send_request(CMD_ALLOC, 12'd0, 13'd1, g);        // full, fails
      send_request(CMD_FREE, 12'hFFF, 13'h1FFF, g);    // runs off the top
      send_request(CMD_ALLOC, 12'd0, 13'd2, g);
      send_request(CMD_ALLOC, 12'hAAA, 13'd1, g);      // start ignored
      send_request(CMD_FREE, 12'd0, 13'd4096, g);
      send_request(CMD_ALLOC, 12'd0, 13'h1FFF, g);     // longer than managed
      send_request(CMD_ALLOC, 12'h555, 13'd4095, g);
      // nothing managed
      write_managed_pages(13'd0);
      send_request(CMD_ALLOC, 12'd0, 13'd1, g);
      send_request(CMD_FREE, 12'd0, 13'd1, g);
      // above the bitmap size, search is capped
      write_managed_pages(13'h1FFF);
      send_request(CMD_FREE, 12'd0, 13'd4096, g);
      send_request(CMD_ALLOC, 12'd0, 13'd4096, g);
      send_request(CMD_FREE, 12'd0, 13'd4096, g);
      // a single managed page
      write_managed_pages(13'd1);
      send_request(CMD_ALLOC, 12'd0, 13'd2, g);
      send_request(CMD_ALLOC, 12'd0, 13'd1, g);
      send_request(CMD_ALLOC, 12'd0, 13'd1, g);        // page 1 free but unmanaged
      send_request(CMD_FREE, 12'd2048, 13'd5, g);      // outside managed, still cleared
      send_request(CMD_FREE, 12'd0, 13'd1, g);
      send_request(CMD_ALLOC, 12'd0, 13'd1, g);
   endtask

   // alloc/free pairs with random sizes, plus stray frees and odd allocs
   task automatic test_random_traffic(input logic [MANAGED_W-1:0] pages, input int n_items);
      page_grant_type g;
      page_run_type   run;
      int             r;
      int             sel;
      write_managed_pages(pages);
      held_runs.delete();
      send_request(CMD_FREE, 12'd0, 13'h1FFF, g);
      for (int i = 1; i < n_items; i++) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            run.count = pick_count();
            run.first = START_W'($urandom_range(0, 4095));
            send_request(CMD_ALLOC, run.first, run.count, g);
            if (g.found) begin
               run.first = g.page_index;
               held_runs.push_back(run);
            end
         end else if (r < 85 && held_runs.size() != 0) begin
            sel = $urandom_range(0, held_runs.size() - 1);
            send_request(CMD_FREE, held_runs[sel].first, held_runs[sel].count, g);
            held_runs.delete(sel);
         end else if (r < 93) begin
            send_request(CMD_FREE, START_W'($urandom_range(0, 4095)), pick_count(), g);
         end else if (r < 97) begin
            send_request(CMD_ALLOC, START_W'($urandom_range(0, 4095)),
                         COUNT_W'($urandom_range(0, 8191)), g);
         end else begin
            send_request(CMD_FREE, 12'd0, 13'd4096, g);
            held_runs.delete();
         end
      end
   endtask

   // back-to-back beats with the result side always ready
   task automatic test_no_idle_stretch();
      wait_drained();
      send_gaps_on  = 1'b0;
      rsp_stalls_on = 1'b0;
      test_random_traffic(13'd512, 100);
      send_gaps_on  = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   // result side holds off long enough for the request side to stall
   task automatic test_output_backpressure();
      page_grant_type g;
      wait_drained();
      send_gaps_on  = 1'b0;
      rsp_hold_left = 400;
      for (int i = 0; i < 40; i++) begin
         if (i % 2 == 0) send_request(CMD_ALLOC, 12'd0, COUNT_W'($urandom_range(1, 6)), g);
         else send_request(CMD_FREE, START_W'($urandom_range(0, 255)),
                           COUNT_W'($urandom_range(1, 6)), g);
      end
      send_gaps_on = 1'b1;
   endtask

   // sender goes quiet until every grant is back, then carries on
   task automatic test_drain_pause();
      page_grant_type g;
      for (int i = 0; i < 60; i++) begin
         if (i % 15 == 14) wait_drained();
         send_request(CMD_W'($urandom_range(0, 1)), START_W'($urandom_range(0, 4095)),
                      pick_count(), g);
      end
   endtask

   // result sink: random stalls, plus the long hold-off when asked
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            rsp_hold_left--;
         end else if (rsp_stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            rsp_stall_left--;
         end else if (rsp_stalls_on && $urandom_range(0, 99) < 20) begin
            rsp_bus.ready  = 1'b0;
            rsp_stall_left = pick_gap();
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // compare each result beat with the oldest pending grant
   always @(posedge clock) begin
      page_grant_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         n_checked++;
         if (pending_grants.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= REPORT_MAX)
               $display("%0t: unexpected result beat found=%0b page_index=%0d",
                        $time, rsp_bus.found, rsp_bus.page_index);
         end else begin
            want = pending_grants.pop_front();
            if (rsp_bus.found !== want.found || rsp_bus.page_index !== want.page_index) begin
               n_mismatch++;
               if (n_mismatch <= REPORT_MAX)
                  $display(
                     "%0t: expected found=%0b page_index=%0d, got found=%0b page_index=%0d",
                     $time, want.found, want.page_index,
                     rsp_bus.found, rsp_bus.page_index);
            end
         end
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles, %0d grants pending",
                  $time, idle_cycles, pending_grants.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // test sequence
   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_bus.valid      = 1'b0;
      req_bus.command    = CMD_ALLOC;
      req_bus.start_page = '0;
      req_bus.page_count = '0;
      page_used          = '1;
      managed_model      = MANAGED_RESET[MANAGED_W-1:0];
      send_gaps_on       = 1'b1;
      rsp_stalls_on      = 1'b1;
      rsp_hold_left      = 0;
      rsp_stall_left     = 0;
      idle_cycles        = 0;
      n_alloc = 0; n_granted = 0; n_free = 0;
      n_settings = 0; n_checked = 0; n_mismatch = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_after_reset();
      test_edge_cases();
      test_random_traffic(13'd4096, 300);
      test_random_traffic(13'd1, 40);
      test_random_traffic(13'h1FFF, 200);
      test_random_traffic(MANAGED_W'($urandom_range(2, 4095)), 250);
      test_random_traffic(13'd0, 40);
      test_random_traffic(13'd64, 150);
      test_no_idle_stretch();
      test_output_backpressure();
      test_random_traffic(13'd4096, 60);
      test_drain_pause();

      wait_drained();
      repeat (20) @(negedge clock);
      $display(
         "Covered %0d allocations (%0d granted) and %0d frees over %0d register settings,",
         n_alloc, n_granted, n_free, n_settings);
      $display("with %0d result beats checked and %0d mismatches.", n_checked, n_mismatch);
      if (n_mismatch == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
